// ----- hw/rtl/dltq_pkg.sv -----
// ----------------------------------------------------------------------------
// Delta-list timer queue package
// Item types, result kinds and opcodes used by the timer queue core.
// ----------------------------------------------------------------------------
package dltq_pkg;

    localparam int DELTA_W = 26;
    localparam int KEY_W   = 16;
    localparam int TIME_W  = 24;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_TICK   = 2'd1,
        OP_FIND   = 2'd2,
        OP_REMOVE = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        KIND_EXPIRED  = 3'd0,
        KIND_FIND     = 3'd1,
        KIND_INSERTED = 3'd2,
        KIND_FULL     = 3'd3,
        KIND_IDLE     = 3'd4
    } kind_t;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] elapsed;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [KEY_W-1:0]  timer_key;
        logic              found;
        logic [TIME_W-1:0] remaining;
        logic              last;
    } out_item_t;

    localparam logic signed [DELTA_W-1:0] DELTA_MAX = {1'b0, {(DELTA_W-1){1'b1}}};
    localparam logic signed [DELTA_W-1:0] DELTA_MIN = {1'b1, {(DELTA_W-1){1'b0}}};
    localparam logic signed [DELTA_W-1:0] REM_MAX   = DELTA_W'(24'hFFFFFF);

    // Saturating signed add of two 26-bit deltas.
    function automatic logic signed [DELTA_W-1:0] sat_add(
        input logic signed [DELTA_W-1:0] a,
        input logic signed [DELTA_W-1:0] b
    );
        logic signed [DELTA_W:0] s;
        s = {a[DELTA_W-1], a} + {b[DELTA_W-1], b};
        if (s[DELTA_W] != s[DELTA_W-1]) begin
            sat_add = s[DELTA_W] ? DELTA_MIN : DELTA_MAX;
        end else begin
            sat_add = s[DELTA_W-1:0];
        end
    endfunction

    // Saturating signed difference of two 26-bit deltas.
    function automatic logic signed [DELTA_W-1:0] sat_sub(
        input logic signed [DELTA_W-1:0] a,
        input logic signed [DELTA_W-1:0] b
    );
        logic signed [DELTA_W:0] s;
        s = {a[DELTA_W-1], a} - {b[DELTA_W-1], b};
        if (s[DELTA_W] != s[DELTA_W-1]) begin
            sat_sub = s[DELTA_W] ? DELTA_MIN : DELTA_MAX;
        end else begin
            sat_sub = s[DELTA_W-1:0];
        end
    endfunction

endpackage

// ----- hw/rtl/delta_list_timer_queue_core.sv -----
// ----------------------------------------------------------------------------
// Delta-list timer queue core
// Sorted list of pending timers kept as relative delays in linked storage.
// ----------------------------------------------------------------------------
// Channel | Direction | Ports              | Payload
// input   | in        | s_valid, s_ready   | s_item  (dltq_pkg::in_item_t)
// result  | out       | m_valid, m_ready   | m_item  (dltq_pkg::out_item_t)
//
// An insert or find walks the linked entries one at a time, reading each entry
// from the entry memory in ST_RD and comparing it in ST_CHK.
// A tick runs ST_TSUB, ST_TNXT and ST_TCHK, then ST_FIX, ST_TNXT and ST_TCHK
// for each expired entry; each expired item is held back until it is known
// whether another one follows. After reset the link memory is chained into a
// free list, one entry a cycle, and no item is accepted until that is done.
// A stalled result holds the sequencer; nothing is lost.
// ----------------------------------------------------------------------------
module delta_list_timer_queue_core #(
    parameter int CAPACITY = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  dltq_pkg::in_item_t   s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output dltq_pkg::out_item_t  m_item
);
    import dltq_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MAX_RESULTS = 64;
    localparam int NW = $clog2(MAX_RESULTS + 1);

    typedef enum logic [9:0] {
        ST_CLEAR = 10'b0000000001,
        ST_IDLE  = 10'b0000000010,
        ST_RD    = 10'b0000000100,
        ST_CHK   = 10'b0000001000,
        ST_INS   = 10'b0000010000,
        ST_FIX   = 10'b0000100000,
        ST_TSUB  = 10'b0001000000,
        ST_TCHK  = 10'b0010000000,
        ST_TNXT  = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } state_t;

    logic [KEY_W-1:0]   key_mem   [CAPACITY];
    logic [DELTA_W-1:0] delta_mem [CAPACITY];
    logic [IW-1:0]      next_mem  [CAPACITY];

    state_t state_reg, state_next;
    logic [IW-1:0] head_reg, free_reg, cur_reg, prev_reg;
    logic [CW-1:0] used_reg, idx_reg;
    logic          have_prev_reg;
    logic [NW-1:0] nres_reg;
    logic signed [DELTA_W-1:0] acc_reg;
    in_item_t      in_reg;
    logic          out_valid_reg;
    out_item_t     out_reg;
    logic [KEY_W-1:0] held_key_reg;

    logic [KEY_W-1:0]   rd_key;
    logic signed [DELTA_W-1:0] rd_delta;
    logic [IW-1:0]      rd_next;
    logic [IW-1:0]      rd_addr;

    // Every stage that needs a read sets rd_addr ahead of it, since the memory read is registered.
    always_ff @(posedge aclk) begin
        rd_key   <= key_mem[rd_addr];
        rd_delta <= delta_mem[rd_addr];
        rd_next  <= next_mem[rd_addr];
    end

    logic wr_en_k, wr_en_d, wr_en_n;
    logic [IW-1:0] wa_k, wa_d, wa_n;
    logic [KEY_W-1:0] wd_k;
    logic [DELTA_W-1:0] wd_d;
    logic [IW-1:0] wd_n;

    always_ff @(posedge aclk) begin
        if (wr_en_k) key_mem[wa_k] <= wd_k;
        if (wr_en_d) delta_mem[wa_d] <= wd_d;
        if (wr_en_n) next_mem[wa_n] <= wd_n;
    end

    assign s_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    logic signed [DELTA_W-1:0] sum_now;
    assign sum_now = sat_add(acc_reg, rd_delta);

    logic find_hit;
    assign find_hit = (rd_key == in_reg.key);

    logic tick_exp;
    assign tick_exp = (used_reg != '0) && (nres_reg != NW'(MAX_RESULTS)) && (rd_delta <= 0);

    logic      emit;
    out_item_t emit_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            head_reg      <= '0;
            free_reg      <= '0;
            used_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            nres_reg      <= '0;
            have_prev_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
                out_reg       <= emit_item;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    idx_reg <= idx_reg + 1'b1;
                end
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        in_reg        <= s_item;
                        cur_reg       <= head_reg;
                        idx_reg       <= '0;
                        have_prev_reg <= 1'b0;
                        nres_reg      <= '0;
                        if (s_item.opcode == OP_INSERT) begin
                            acc_reg <= (s_item.delay == '0) ? DELTA_W'(1)
                                                            : DELTA_W'(s_item.delay);
                        end else begin
                            acc_reg <= '0;
                        end
                    end
                end
                ST_CHK: begin
                    if (in_reg.opcode == OP_INSERT) begin
                        if (rd_delta < acc_reg) begin
                            acc_reg       <= sat_sub(acc_reg, rd_delta);
                            prev_reg      <= cur_reg;
                            have_prev_reg <= 1'b1;
                            cur_reg       <= rd_next;
                            idx_reg       <= idx_reg + 1'b1;
                        end
                    end else if (find_hit) begin
                        if (in_reg.opcode == OP_REMOVE) begin
                            if (!have_prev_reg) head_reg <= rd_next;
                            used_reg <= used_reg - 1'b1;
                            free_reg <= cur_reg;
                            // The successor takes over the removed delta.
                            acc_reg  <= rd_delta;
                            cur_reg  <= rd_next;
                            idx_reg  <= idx_reg + 1'b1;
                        end
                    end else begin
                        acc_reg       <= sum_now;
                        prev_reg      <= cur_reg;
                        have_prev_reg <= 1'b1;
                        cur_reg       <= rd_next;
                        idx_reg       <= idx_reg + 1'b1;
                    end
                end
                ST_INS: begin
                    free_reg <= rd_next;
                    if (!have_prev_reg) head_reg <= free_reg;
                    used_reg <= used_reg + 1'b1;
                    cur_reg  <= free_reg;
                end
                ST_TCHK: begin
                    if (tick_exp) begin
                        held_key_reg <= rd_key;
                        head_reg     <= rd_next;
                        free_reg     <= cur_reg;
                        used_reg     <= used_reg - 1'b1;
                        acc_reg      <= rd_delta;
                        cur_reg      <= rd_next;
                        nres_reg     <= nres_reg + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        rd_addr    = cur_reg;
        wr_en_k = 1'b0; wr_en_d = 1'b0; wr_en_n = 1'b0;
        wa_k = cur_reg; wa_d = cur_reg; wa_n = cur_reg;
        wd_k = in_reg.key; wd_d = acc_reg; wd_n = '0;
        emit      = 1'b0;
        emit_item = '0;
        case (state_reg)
            ST_CLEAR: begin
                wr_en_n = 1'b1;
                wa_n = idx_reg[IW-1:0];
                wd_n = (idx_reg == CW'(CAPACITY - 1)) ? '0 : IW'(idx_reg + 1'b1);
                if (idx_reg == CW'(CAPACITY - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                rd_addr = head_reg;
                if (s_valid && s_ready) begin
                    case (opcode_t'(s_item.opcode))
                        OP_INSERT: state_next = (used_reg == CW'(CAPACITY)) ? ST_OUT : ST_RD;
                        OP_TICK:   state_next = ST_TSUB;
                        default:   state_next = ST_RD;
                    endcase
                end
            end
            ST_RD: begin
                if (idx_reg == used_reg) begin
                    state_next = (in_reg.opcode == OP_INSERT) ? ST_INS : ST_OUT;
                    rd_addr = free_reg;
                end else begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                if (in_reg.opcode == OP_INSERT) begin
                    if (rd_delta < acc_reg) begin
                        rd_addr = rd_next;
                        state_next = ST_RD;
                    end else begin
                        wr_en_d = 1'b1;
                        wd_d = sat_sub(rd_delta, acc_reg);
                        rd_addr = free_reg;
                        state_next = ST_INS;
                    end
                end else if (find_hit) begin
                    emit = 1'b1;
                    emit_item.kind      = KIND_FIND;
                    emit_item.timer_key = in_reg.key;
                    emit_item.found     = 1'b1;
                    emit_item.last      = 1'b1;
                    if (sum_now < 0) begin
                        emit_item.remaining = '0;
                    end else if (sum_now > REM_MAX) begin
                        emit_item.remaining = '1;
                    end else begin
                        emit_item.remaining = sum_now[TIME_W-1:0];
                    end
                    if (in_reg.opcode == OP_REMOVE) begin
                        wr_en_n = 1'b1;
                        wa_n = cur_reg;
                        wd_n = free_reg;
                        rd_addr = rd_next;
                        state_next = ST_FIX;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    rd_addr = rd_next;
                    state_next = ST_RD;
                end
            end
            ST_FIX: begin
                case (opcode_t'(in_reg.opcode))
                    OP_INSERT: begin
                        wr_en_n = 1'b1;
                        wa_n = prev_reg;
                        wd_n = cur_reg;
                        state_next = ST_IDLE;
                    end
                    OP_TICK: begin
                        if (acc_reg < 0 && used_reg != '0) begin
                            wr_en_d = 1'b1;
                            wa_d = cur_reg;
                            wd_d = sat_add(rd_delta, acc_reg);
                        end
                        state_next = ST_TNXT;
                    end
                    default: begin
                        // Relinks the predecessor, if any, and folds the delta into the successor, if any.
                        if (have_prev_reg) begin
                            wr_en_n = 1'b1;
                            wa_n = prev_reg;
                            wd_n = cur_reg;
                        end
                        if (idx_reg <= used_reg) begin
                            wr_en_d = 1'b1;
                            wa_d = cur_reg;
                            wd_d = sat_add(rd_delta, acc_reg);
                        end
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_INS: begin
                wr_en_k = 1'b1; wa_k = free_reg; wd_k = in_reg.key;
                wr_en_d = 1'b1; wa_d = free_reg; wd_d = acc_reg;
                wr_en_n = 1'b1; wa_n = free_reg;
                wd_n = (idx_reg < used_reg) ? cur_reg : '0;
                emit = 1'b1;
                emit_item.kind = KIND_INSERTED;
                emit_item.last = 1'b1;
                state_next = have_prev_reg ? ST_FIX : ST_IDLE;
            end
            ST_TSUB: begin
                if (used_reg != '0) begin
                    wr_en_d = 1'b1;
                    wa_d = head_reg;
                    wd_d = sat_sub(rd_delta, DELTA_W'(in_reg.elapsed));
                end
                rd_addr = head_reg;
                state_next = ST_TNXT;
            end
            ST_TNXT: begin
                rd_addr = head_reg;
                state_next = out_valid_reg ? ST_TNXT : ST_TCHK;
            end
            ST_TCHK: begin
                if (tick_exp) begin
                    if (nres_reg != '0) begin
                        emit = 1'b1;
                        emit_item.kind      = KIND_EXPIRED;
                        emit_item.timer_key = held_key_reg;
                    end
                    wr_en_n = 1'b1;
                    wa_n = cur_reg;
                    wd_n = free_reg;
                    rd_addr = rd_next;
                    state_next = ST_FIX;
                end else begin
                    emit = 1'b1;
                    emit_item.last = 1'b1;
                    if (nres_reg == '0) begin
                        emit_item.kind = KIND_IDLE;
                    end else begin
                        emit_item.kind      = KIND_EXPIRED;
                        emit_item.timer_key = held_key_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                emit = 1'b1;
                emit_item.last = 1'b1;
                if (in_reg.opcode == OP_INSERT) begin
                    emit_item.kind = KIND_FULL;
                end else begin
                    emit_item.kind      = KIND_FIND;
                    emit_item.timer_key = in_reg.key;
                end
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
